>>> rtl/mpfb_pkg.sv
// Shared types and constants for the page-mode frame store.
package mpfb_pkg;

    localparam int DEF_WIDTH  = 128;
    localparam int DEF_HEIGHT = 64;

    typedef enum logic [2:0] {
        MODE_PIXEL  = 3'd0,
        MODE_READ   = 3'd1,
        MODE_HLINE  = 3'd2,
        MODE_VLINE  = 3'd3,
        MODE_RECT   = 3'd4,
        MODE_SCREEN = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        INK_CLEAR  = 2'd0,
        INK_SET    = 2'd1,
        INK_INVERT = 2'd2
    } ink_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CLEAR,
        BK_RUN,
        BK_READ
    } bk_state_t;

    // Clipped command handed from the front to the back.
    // Region is [x0,x1) x [y0,y1); the back sweeps columns and pages.
    typedef struct packed {
        logic        is_read;
        logic        is_fill;
        logic [1:0]  ink;
        logic [10:0] x0;
        logic [10:0] x1;
        logic [8:0]  y0;
        logic [8:0]  y1;
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);

    function automatic logic [7:0] head_mask(input logic [2:0] lo);
        return 8'hFF << lo;
    endfunction

    function automatic logic [7:0] tail_mask(input logic [3:0] hi);
        return 8'hFF >> (4'd8 - hi);
    endfunction

endpackage

>>> rtl/mpfb_front.sv
// Front end: accepts commands, clips them and pushes them into the queue.
module mpfb_front #(
    parameter int DISPLAY_WIDTH  = mpfb_pkg::DEF_WIDTH,
    parameter int DISPLAY_HEIGHT = mpfb_pkg::DEF_HEIGHT
) (
    input  logic                valid,
    output logic                ready,
    input  logic [2:0]          mode,
    input  logic signed [15:0]  col,
    input  logic signed [15:0]  row,
    input  logic signed [15:0]  span_w,
    input  logic signed [15:0]  span_h,
    input  logic [1:0]          ink,
    output logic                push,
    output mpfb_pkg::cmd_t      push_cmd,
    input  logic                q_full
);
    import mpfb_pkg::*;

    localparam logic signed [17:0] W = 18'(DISPLAY_WIDTH);
    localparam logic signed [17:0] H = 18'(DISPLAY_HEIGHT);

    logic signed [17:0] xs, ys, xe, ye, cx0, cx1, cy0, cy1;
    logic x_on, y_on, wpos, hpos, draw;
    cmd_t c;

    assign ready = !q_full;

    always_comb
    begin
        xs   = 18'(col);
        ys   = 18'(row);
        xe   = xs + 18'(span_w);
        ye   = ys + 18'(span_h);
        x_on = (xs >= 0) && (xs < W);
        y_on = (ys >= 0) && (ys < H);
        wpos = span_w > 0;
        hpos = span_h > 0;
        cx0  = (xs < 0) ? 18'sd0 : xs;
        cx1  = (xe > W) ? W : xe;
        cy0  = (ys < 0) ? 18'sd0 : ys;
        cy1  = (ye > H) ? H : ye;
        c         = '0;
        c.ink     = (ink == INK_CLEAR || ink == INK_SET) ? ink : INK_INVERT;
        draw      = 1'b0;
        case (mode)
            MODE_PIXEL:
            begin
                draw = x_on && y_on;
                c.x0 = xs[10:0]; c.x1 = 11'(xs + 1);
                c.y0 = ys[8:0];  c.y1 = 9'(ys + 1);
            end
            MODE_READ:
            begin
                draw = 1'b1;
                c.is_read = 1'b1;
                c.is_fill = !(x_on && y_on);
                c.x0 = xs[10:0]; c.y0 = ys[8:0];
            end
            MODE_HLINE:
            begin
                draw = y_on && wpos && (cx0 < cx1);
                c.x0 = cx0[10:0]; c.x1 = cx1[10:0];
                c.y0 = ys[8:0];   c.y1 = 9'(ys + 1);
            end
            MODE_VLINE:
            begin
                draw = x_on && hpos && (cy0 < cy1);
                c.x0 = xs[10:0];  c.x1 = 11'(xs + 1);
                c.y0 = cy0[8:0];  c.y1 = cy1[8:0];
            end
            MODE_RECT:
            begin
                draw = wpos && hpos && (cx0 < cx1) && (cy0 < cy1);
                c.x0 = cx0[10:0]; c.x1 = cx1[10:0];
                c.y0 = cy0[8:0];  c.y1 = cy1[8:0];
            end
            MODE_SCREEN:
            begin
                draw = 1'b1;
                c.is_fill = 1'b1;
                c.ink = (ink == INK_CLEAR) ? INK_CLEAR : INK_SET;
                c.x0 = '0; c.x1 = 11'(DISPLAY_WIDTH);
                c.y0 = '0; c.y1 = 9'(DISPLAY_HEIGHT);
            end
            default: draw = 1'b0;
        endcase
    end

    assign push     = valid && ready && draw;
    assign push_cmd = c;

endmodule

>>> rtl/mpfb_queue.sv
// Two-entry command queue between front and back.
module mpfb_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mpfb_pkg::cmd_t push_cmd,
    output logic           full,
    output logic           not_empty,
    input  logic           pop,
    output mpfb_pkg::cmd_t head
);
    import mpfb_pkg::*;

    cmd_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full      = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign head      = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty) else $error("queue underflow");
    a_count: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count out of range");
`endif

endmodule

>>> rtl/mpfb_back.sv
// Back end: frame store, clearing pass and byte-by-byte region sweep.
module mpfb_back #(
    parameter int DISPLAY_WIDTH  = mpfb_pkg::DEF_WIDTH,
    parameter int DISPLAY_HEIGHT = mpfb_pkg::DEF_HEIGHT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           not_empty,
    input  mpfb_pkg::cmd_t head,
    output logic           pop,
    output logic           pixel_on,
    output logic           out_valid,
    input  logic           out_ready
);
    import mpfb_pkg::*;

    localparam int PAGES = (DISPLAY_HEIGHT + 7) / 8;
    localparam int DEPTH = DISPLAY_WIDTH * PAGES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DISPLAY_WIDTH + 1);
    localparam int PW    = $clog2(PAGES + 1);

    logic [7:0] store [DEPTH];

    bk_state_t  st_reg, st_next;
    cmd_t       cmd_reg, cmd_next;
    logic [CW-1:0] c_reg, c_next;
    logic [PW-1:0] p_reg, p_next;
    logic       ph_reg, ph_next;
    logic [AW:0] clr_reg, clr_next;
    logic       ov_reg, ov_next;
    logic       od_reg, od_next;
    logic [7:0] rd_reg;
    logic [2:0] bit_reg, bit_next;
    logic       rfill_reg, rfill_next;

    logic       busy;
    logic       we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0] wdata, mask;
    logic [8:0] base;
    logic [2:0] lo;
    logic [3:0] hi;
    logic       last_p, last_c;

    always_comb
    begin
        base = 9'(p_reg) << 3;
        lo   = (cmd_reg.y0 > base) ? 3'(cmd_reg.y0 - base) : 3'd0;
        hi   = (cmd_reg.y1 < base + 9'd8) ? 4'(cmd_reg.y1 - base) : 4'd8;
        mask = head_mask(lo) & tail_mask(hi);
        last_p = p_reg == PW'((cmd_reg.y1 - 9'd1) >> 3);
        last_c = c_reg == CW'(cmd_reg.x1 - 11'd1);
        raddr  = AW'(p_reg) * AW'(DISPLAY_WIDTH) + AW'(c_reg);
        case (cmd_reg.ink)
            INK_CLEAR: wdata = rd_reg & ~mask;
            INK_SET:   wdata = rd_reg | mask;
            default:   wdata = rd_reg ^ mask;
        endcase
        if (cmd_reg.is_fill)
            wdata = (cmd_reg.ink == INK_CLEAR) ? 8'h00 : 8'hFF;
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= store[raddr];
        if (we)
            store[waddr] <= (st_reg == BK_CLEAR) ? 8'h00 : wdata;
    end

    always_comb
    begin
        st_next    = st_reg;
        cmd_next   = cmd_reg;
        c_next     = c_reg;
        p_next     = p_reg;
        ph_next    = ph_reg;
        clr_next   = clr_reg;
        ov_next    = ov_reg;
        od_next    = od_reg;
        bit_next   = bit_reg;
        rfill_next = rfill_reg;
        pop        = 1'b0;
        we         = 1'b0;
        waddr      = raddr;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        case (st_reg)
            BK_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg[AW-1:0];
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(DEPTH - 1))
                    st_next = BK_IDLE;
            end
            BK_IDLE:
            begin
                if (not_empty && !(head.is_read && ov_reg && !out_ready))
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    c_next   = CW'(head.x0);
                    p_next   = PW'(head.y0 >> 3);
                    ph_next  = 1'b0;
                    st_next  = head.is_read ? BK_READ : BK_RUN;
                    bit_next = head.y0[2:0];
                    rfill_next = head.is_fill;
                end
            end
            BK_READ:
            begin
                if (!ph_reg)
                    ph_next = 1'b1;
                else
                begin
                    ov_next = 1'b1;
                    od_next = !rfill_reg && rd_reg[bit_reg];
                    st_next = BK_IDLE;
                end
            end
            BK_RUN:
            begin
                if (!ph_reg && !cmd_reg.is_fill)
                    ph_next = 1'b1;
                else
                begin
                    we      = 1'b1;
                    ph_next = 1'b0;
                    if (last_p)
                    begin
                        p_next = PW'(cmd_reg.y0 >> 3);
                        c_next = c_reg + 1'b1;
                        if (last_c)
                            st_next = BK_IDLE;
                    end
                    else
                        p_next = p_reg + 1'b1;
                end
            end
            default: st_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= BK_CLEAR;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
            od_reg    <= 1'b0;
            c_reg     <= '0;
            p_reg     <= '0;
            ph_reg    <= 1'b0;
            cmd_reg   <= '0;
            bit_reg   <= '0;
            rfill_reg <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
            od_reg    <= od_next;
            c_reg     <= c_next;
            p_reg     <= p_next;
            ph_reg    <= ph_next;
            cmd_reg   <= cmd_next;
            bit_reg   <= bit_next;
            rfill_reg <= rfill_next;
        end
    end

    assign busy      = st_reg == BK_CLEAR;
    assign out_valid = ov_reg;
    assign pixel_on  = od_reg;

`ifndef SYNTHESIS
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !pop) else $error("command taken during clearing pass");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready) |=> (ov_reg && $stable(od_reg)))
        else $error("result dropped while stalled");
    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == BK_READ && ph_reg) |=> ov_reg) else $error("read result missing");
`endif

endmodule

>>> rtl/mono_page_framebuffer_draw.sv
// Top level of the page-mode monochrome frame store with drawing commands.
// Input channel: valid/ready with mode, col, row, span_w, span_h, ink.
// Output channel: out_valid/out_ready carrying pixel_on, one per read.
// Commands are clipped by the front end and queued (two entries) for the
// back end, which owns the frame store.
// Pixel draw and read: the back end steps through dispatch, read, then
// write or result; out_valid rises, from a registered result, once an
// accepted read has passed the queue and these steps with the back end idle.
// Lines and rectangles: a dispatch step, then a read and a write per
// touched byte; whole-screen fill: a dispatch step, then one write per byte.
// Commands that clip to nothing retire in the cycle they are accepted.
// At reset the store is cleared by a pass that writes each of the
// DISPLAY_WIDTH * ceil(DISPLAY_HEIGHT/8) bytes in turn; commands are
// queued but not run meanwhile.
// A read result waits in an output register while out_ready is low;
// draws ahead of the next read carry on, that read and all behind it wait.
module mono_page_framebuffer_draw #(
    parameter int DISPLAY_WIDTH  = mpfb_pkg::DEF_WIDTH,
    parameter int DISPLAY_HEIGHT = mpfb_pkg::DEF_HEIGHT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    output logic               ready,
    input  logic [2:0]         mode,
    input  logic signed [15:0] col,
    input  logic signed [15:0] row,
    input  logic signed [15:0] span_w,
    input  logic signed [15:0] span_h,
    input  logic [1:0]         ink,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               pixel_on
);
    import mpfb_pkg::*;

    logic push, full, not_empty, pop;
    cmd_t push_cmd, head;

    mpfb_front #(.DISPLAY_WIDTH(DISPLAY_WIDTH), .DISPLAY_HEIGHT(DISPLAY_HEIGHT)) u_front (
        .valid, .ready, .mode, .col, .row, .span_w, .span_h, .ink,
        .push, .push_cmd, .q_full(full)
    );

    mpfb_queue u_queue (
        .clk, .rst_n, .push, .push_cmd, .full, .not_empty, .pop, .head
    );

    mpfb_back #(.DISPLAY_WIDTH(DISPLAY_WIDTH), .DISPLAY_HEIGHT(DISPLAY_HEIGHT)) u_back (
        .clk, .rst_n, .not_empty, .head, .pop, .pixel_on, .out_valid, .out_ready
    );

endmodule
